@@ hdl/assert_macros.svh @@
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`endif

@@ hdl/csim_pkg.sv @@
package csim_pkg;

  localparam int unsigned NUM_SRC = 4;

  // source slots
  localparam logic [1:0] SRC_SPEED   = 2'd0;
  localparam logic [1:0] SRC_STATUS  = 2'd1;
  localparam logic [1:0] SRC_COMMAND = 2'd2;
  localparam logic [1:0] SRC_DIAG    = 2'd3;

  // expected data length codes
  localparam logic [3:0] LEN_SPEED   = 4'd8;
  localparam logic [3:0] LEN_STATUS  = 4'd5;
  localparam logic [3:0] LEN_COMMAND = 4'd5;
  localparam logic [3:0] LEN_DIAG    = 4'd8;

  localparam logic [7:0] GEAR_PARK    = 8'h03;
  localparam logic [7:0] TIMEOUT_MASK = 8'h03;

  localparam logic [31:0] FRESH_LIMIT_RST = 32'd1000;
  localparam logic [31:0] STABLE_TIME_RST = 32'd5000;

  typedef enum logic {
    FUNC_FRAME = 1'b0,
    FUNC_POLL  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    REG_SPEED_ID    = 3'd0,
    REG_STATUS_ID   = 3'd1,
    REG_COMMAND_ID  = 3'd2,
    REG_DIAG_ID     = 3'd3,
    REG_FRESH_LIMIT = 3'd4,
    REG_STABLE_TIME = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [28:0] speed_id;
    logic [28:0] status_id;
    logic [10:0] command_id;
    logic [10:0] diag_id;
    logic [31:0] fresh_limit;
    logic [31:0] stable_time;
  } cfg_t;

  typedef struct packed {
    logic [11:0] motor_speed;
    logic [9:0]  pedal_position;
    logic [9:0]  output_target;
    logic [1:0]  drive_action;
    logic [15:0] throttle_level;
    logic [15:0] regen_level;
    logic        brake_on;
    logic        comm_fault;
    logic [7:0]  gear_state;
    logic [7:0]  timeout_bits;
  } sig_t;

  typedef struct packed {
    logic               matched;
    logic               accepted;
    logic [NUM_SRC-1:0] hit;
    sig_t               sig;
  } dec_t;

  typedef struct packed {
    logic        flag;
    logic [31:0] start;
    logic        allowed;
  } stab_t;

  typedef logic [NUM_SRC-1:0][31:0] src_time_t;

endpackage

@@ hdl/csim_cfg.sv @@
module csim_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output csim_pkg::cfg_t       cfg_o
);
  import csim_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e sel;
  logic     wr_en;

  assign sel    = cfg_reg_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        REG_SPEED_ID:    cfg_d.speed_id    = pwdata[28:0];
        REG_STATUS_ID:   cfg_d.status_id   = pwdata[28:0];
        REG_COMMAND_ID:  cfg_d.command_id  = pwdata[10:0];
        REG_DIAG_ID:     cfg_d.diag_id     = pwdata[10:0];
        REG_FRESH_LIMIT: cfg_d.fresh_limit = pwdata;
        REG_STABLE_TIME: cfg_d.stable_time = pwdata;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    case (sel)
      REG_SPEED_ID:    prdata = {3'd0, cfg_q.speed_id};
      REG_STATUS_ID:   prdata = {3'd0, cfg_q.status_id};
      REG_COMMAND_ID:  prdata = {21'd0, cfg_q.command_id};
      REG_DIAG_ID:     prdata = {21'd0, cfg_q.diag_id};
      REG_FRESH_LIMIT: prdata = cfg_q.fresh_limit;
      REG_STABLE_TIME: prdata = cfg_q.stable_time;
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_id    <= '0;
      cfg_q.status_id   <= '0;
      cfg_q.command_id  <= '0;
      cfg_q.diag_id     <= '0;
      cfg_q.fresh_limit <= FRESH_LIMIT_RST;
      cfg_q.stable_time <= STABLE_TIME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ hdl/csim_decode.sv @@
module csim_decode (
  input  logic           func_i,
  input  logic [28:0]    can_id_i,
  input  logic           is_extended_i,
  input  logic [3:0]     frame_length_i,
  input  logic [63:0]    frame_data_i,
  input  csim_pkg::cfg_t cfg_i,
  output csim_pkg::dec_t dec_o
);
  import csim_pkg::*;

  logic [7:0]         d0, d1, d2, d3, d4, d5, d6;
  logic               is_frame;
  logic [NUM_SRC-1:0] hit;

  assign d0 = frame_data_i[7:0];
  assign d1 = frame_data_i[15:8];
  assign d2 = frame_data_i[23:16];
  assign d3 = frame_data_i[31:24];
  assign d4 = frame_data_i[39:32];
  assign d5 = frame_data_i[47:40];
  assign d6 = frame_data_i[55:48];
  assign is_frame = (func_i == FUNC_FRAME);

  // source match, first configured source wins
  always_comb begin
    hit = '0;
    if (is_frame) begin
      if (is_extended_i && can_id_i == cfg_i.speed_id) begin
        hit[SRC_SPEED] = 1'b1;
      end else if (is_extended_i && can_id_i == cfg_i.status_id) begin
        hit[SRC_STATUS] = 1'b1;
      end else if (!is_extended_i && can_id_i == {18'd0, cfg_i.command_id}) begin
        hit[SRC_COMMAND] = 1'b1;
      end else if (!is_extended_i && can_id_i == {18'd0, cfg_i.diag_id}) begin
        hit[SRC_DIAG] = 1'b1;
      end
    end
  end

  assign dec_o.hit = hit;

  // length check against the matched source
  assign dec_o.matched  = |hit;
  assign dec_o.accepted = (hit[SRC_SPEED]   && frame_length_i == LEN_SPEED)   ||
                          (hit[SRC_STATUS]  && frame_length_i == LEN_STATUS)  ||
                          (hit[SRC_COMMAND] && frame_length_i == LEN_COMMAND) ||
                          (hit[SRC_DIAG]    && frame_length_i == LEN_DIAG);

  // field unpacking, used only by the matching source
  assign dec_o.sig.motor_speed    = {d5[6:0], d4[7:3]};
  assign dec_o.sig.pedal_position = {d1[3:0], d0[7:2]};
  assign dec_o.sig.output_target  = {d4[3:0], d3[7:2]};
  assign dec_o.sig.drive_action   = d4[5:4];
  assign dec_o.sig.throttle_level = {d1, d0};
  assign dec_o.sig.regen_level    = {d3, d2};
  assign dec_o.sig.brake_on       = d4[0];
  assign dec_o.sig.comm_fault     = d4[5];
  assign dec_o.sig.gear_state     = d5;
  assign dec_o.sig.timeout_bits   = d6;

endmodule

@@ hdl/csim_safety.sv @@
module csim_safety (
  input  logic                          run_i,
  input  logic [31:0]                   now_i,
  input  csim_pkg::cfg_t                cfg_i,
  input  csim_pkg::sig_t                sig_i,
  input  logic [csim_pkg::NUM_SRC-1:0]  seen_i,
  input  csim_pkg::src_time_t           time_i,
  input  logic                          flag_i,
  input  logic [31:0]                   start_i,
  output csim_pkg::stab_t               stab_o
);
  import csim_pkg::*;

  logic [NUM_SRC-1:0] fresh;
  logic               sig_ok;
  logic               safe;
  logic [31:0]        held;
  logic               flag_new;
  logic [31:0]        start_new;

  // per-source age check, wrapping difference
  always_comb begin
    for (int s = 0; s < NUM_SRC; s++) begin
      fresh[s] = seen_i[s] && ((now_i - time_i[s]) <= cfg_i.fresh_limit);
    end
  end

  // no motion, park, brake pressed, no faults
  assign sig_ok = (sig_i.motor_speed == '0) && (sig_i.drive_action == '0) &&
                  (sig_i.pedal_position == '0) && (sig_i.output_target == '0) &&
                  (sig_i.throttle_level == '0) && (sig_i.regen_level == '0) &&
                  (sig_i.gear_state == GEAR_PARK) && sig_i.brake_on &&
                  !sig_i.comm_fault && ((sig_i.timeout_bits & TIMEOUT_MASK) == '0);

  assign safe = (&fresh) && sig_ok;

  // stable flag and start time
  always_comb begin
    flag_new  = flag_i;
    start_new = start_i;
    if (run_i) begin
      if (!safe) begin
        flag_new  = 1'b0;
        start_new = '0;
      end else if (!flag_i) begin
        flag_new  = 1'b1;
        start_new = now_i;
      end
    end
  end

  assign held           = now_i - start_new;
  assign stab_o.flag    = flag_new;
  assign stab_o.start   = start_new;
  assign stab_o.allowed = flag_new && (held >= cfg_i.stable_time);

endmodule

@@ hdl/can_safety_interlock_monitor_unit.sv @@
// throughput: one item per cycle unless the result side stalls; input register, one pass of logic, result register
// an empty input register takes a new item in while a result waits to be taken
// reset (rst_ni low, asynchronous): both pipeline stages empty, all stored
// signals, seen flags and stamps cleared, limits back to 1000 ms and 5000 ms
module can_safety_interlock_monitor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [28:0] can_id_i,
  input  logic        is_extended_i,
  input  logic [3:0]  frame_length_i,
  input  logic [63:0] frame_data_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        update_allowed_o,
  output logic        stable_safe_o,
  output logic        frame_accepted_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import csim_pkg::*;

  cfg_t cfg;
  dec_t dec;
  stab_t stab;

  // input register
  logic        s0_valid_q;
  logic        func_q;
  logic [28:0] can_id_q;
  logic        is_ext_q;
  logic [3:0]  len_q;
  logic [63:0] data_q;
  logic [31:0] now_q;

  // monitor state
  logic [NUM_SRC-1:0] seen_q, seen_d;
  src_time_t          time_q, time_d;
  sig_t               sig_q, sig_d;
  logic               flag_q;
  logic [31:0]        start_q;

  // result register
  logic out_valid_q;
  logic allowed_q, safe_q, accepted_q;

  logic out_free, adv, in_acc, is_poll;

  // pipeline control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = s0_valid_q && out_free;
  assign in_stall_o = s0_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_poll    = (func_q == FUNC_POLL);

  csim_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  csim_decode u_decode (
    .func_i         (func_q),
    .can_id_i       (can_id_q),
    .is_extended_i  (is_ext_q),
    .frame_length_i (len_q),
    .frame_data_i   (data_q),
    .cfg_i          (cfg),
    .dec_o          (dec)
  );

  // next state of sources and signals after this item
  always_comb begin
    seen_d = seen_q;
    time_d = time_q;
    sig_d  = sig_q;
    for (int s = 0; s < NUM_SRC; s++) begin
      if (dec.hit[s]) begin
        seen_d[s] = dec.accepted;
        if (dec.accepted) begin
          time_d[s] = now_q;
        end
      end
    end
    if (dec.accepted) begin
      if (dec.hit[SRC_SPEED]) begin
        sig_d.motor_speed = dec.sig.motor_speed;
      end
      if (dec.hit[SRC_STATUS]) begin
        sig_d.pedal_position = dec.sig.pedal_position;
        sig_d.output_target  = dec.sig.output_target;
        sig_d.drive_action   = dec.sig.drive_action;
      end
      if (dec.hit[SRC_COMMAND]) begin
        sig_d.throttle_level = dec.sig.throttle_level;
        sig_d.regen_level    = dec.sig.regen_level;
      end
      if (dec.hit[SRC_DIAG]) begin
        sig_d.brake_on     = dec.sig.brake_on;
        sig_d.comm_fault   = dec.sig.comm_fault;
        sig_d.gear_state   = dec.sig.gear_state;
        sig_d.timeout_bits = dec.sig.timeout_bits;
      end
    end
  end

  csim_safety u_safety (
    .run_i   (is_poll || dec.matched),
    .now_i   (now_q),
    .cfg_i   (cfg),
    .sig_i   (sig_d),
    .seen_i  (seen_d),
    .time_i  (time_d),
    .flag_i  (flag_q),
    .start_i (start_q),
    .stab_o  (stab)
  );

  // input register load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= in_acc || (s0_valid_q && !adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q   <= func_i;
      can_id_q <= can_id_i;
      is_ext_q <= is_extended_i;
      len_q    <= frame_length_i;
      data_q   <= frame_data_i;
      now_q    <= now_ms_i;
    end
  end

  // state update as the item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      time_q  <= '0;
      sig_q   <= '0;
      flag_q  <= 1'b0;
      start_q <= '0;
    end else if (adv) begin
      seen_q  <= seen_d;
      time_q  <= time_d;
      sig_q   <= sig_d;
      flag_q  <= stab.flag;
      start_q <= stab.start;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= adv || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      allowed_q  <= is_poll && stab.allowed;
      safe_q     <= stab.flag;
      accepted_q <= dec.accepted;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign update_allowed_o = allowed_q;
  assign stable_safe_o    = safe_q;
  assign frame_accepted_o = accepted_q;

endmodule

@@ hdl/csim_checker.sv @@
`include "assert_macros.svh"

module csim_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        update_allowed_o,
  input logic        stable_safe_o,
  input logic        frame_accepted_o
);

  logic [2:0] res_fields;

  assign res_fields = {update_allowed_o, stable_safe_o, frame_accepted_o};

  // a stalled result keeps its value
  `ASSERT_RST(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(res_fields))

  // permission is only granted while the stable flag is set
  `ASSERT_RST(a_allowed_safe, out_valid_o && update_allowed_o |-> stable_safe_o)

  // a result is either a poll answer or a frame answer
  `ASSERT_RST(a_poll_or_frame, out_valid_o |-> !(update_allowed_o && frame_accepted_o))

  // reset leaves both sides empty
  `ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o && !in_stall_o)

endmodule

bind can_safety_interlock_monitor_unit csim_checker u_checker (.*);

@@ tb/tb_can_safety_interlock_monitor_unit.sv @@
`timescale 1ns / 1ps

module tb_can_safety_interlock_monitor_unit;
  import csim_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_ITEMS   = 165;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned RESET_ROWS    = 2;
  localparam int unsigned DIRECTED_ROWS = 26;

  // register slots past the end of the map, writes there must be dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // source ids used by the directed rows
  localparam logic [28:0] DIR_SPEED_ID  = 29'h1FFFFFFF;
  localparam logic [28:0] DIR_STATUS_ID = 29'h0AAAAAAA;
  localparam logic [28:0] DIR_CMD_ID    = 29'h000007FF;
  localparam logic [28:0] DIR_DIAG_ID   = 29'h00000155;

  typedef struct packed {
    func_e       func;
    logic [28:0] can_id;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] data;
    logic [31:0] now;
  } frame_item_t;

  typedef struct packed {
    logic allowed;
    logic safe;
    logic accepted;
  } verdict_t;

  typedef struct packed {
    func_e       func;
    logic [28:0] can_id;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] data;
    logic [31:0] now;
    logic        typed;
    verdict_t    want;
  } directed_row_t;

  // columns: func, id, ext, length, payload, ms, typed, {allowed, safe, accepted}
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // reset ids are all zero, so an extended id 0 frame lands on the speed source
    '{FUNC_POLL,  29'h0, 1'b0, 4'd0, 64'h0, 32'd0, 1'b1, 3'b000},
    '{FUNC_FRAME, 29'h0, 1'b1, LEN_SPEED, 64'h0, 32'd10, 1'b1, 3'b001},
    // all four sources at rest, bits outside the signals set
    '{FUNC_FRAME, DIR_SPEED_ID, 1'b1, LEN_SPEED, 64'hFFFF8007_FFFFFFFF, 32'd100, 1'b1, 3'b001},
    '{FUNC_FRAME, DIR_STATUS_ID, 1'b1, LEN_STATUS, 64'hFFFFFFC0_03FFF003, 32'd100, 1'b1,
      3'b001},
    '{FUNC_FRAME, DIR_CMD_ID, 1'b0, LEN_COMMAND, 64'hFFFFFFFF_00000000, 32'd100, 1'b1, 3'b001},
    '{FUNC_FRAME, DIR_DIAG_ID, 1'b0, LEN_DIAG, 64'hFFFC03DF_FFFFFFFF, 32'd100, 1'b0, 3'b000},
    // just short of and exactly at the stable time
    '{FUNC_POLL,  29'h0, 1'b0, 4'd0, 64'h0, 32'd5099, 1'b0, 3'b000},
    '{FUNC_POLL,  29'h0, 1'b0, 4'd0, 64'h0, 32'd5100, 1'b0, 3'b000},
    // wrong length drops the source
    '{FUNC_FRAME, DIR_CMD_ID, 1'b0, 4'd4, 64'h0, 32'd5200, 1'b1, 3'b000},
    '{FUNC_POLL,  29'h0, 1'b0, 4'd0, 64'h0, 32'd5300, 1'b1, 3'b000},
    '{FUNC_FRAME, DIR_CMD_ID, 1'b0, LEN_COMMAND, 64'h0, 32'd5400, 1'b0, 3'b000},
    // unknown id, oversized standard id, standard id sent as extended
    '{FUNC_FRAME, 29'h00000123, 1'b1, LEN_SPEED, 64'h0, 32'd5500, 1'b0, 3'b000},
    '{FUNC_FRAME, 29'h1FFFF7FF, 1'b0, LEN_COMMAND, 64'h0, 32'd5600, 1'b0, 3'b000},
    '{FUNC_FRAME, DIR_CMD_ID, 1'b1, LEN_COMMAND, 64'h0, 32'd5700, 1'b0, 3'b000},
    // motion and fault signals one at a time
    '{FUNC_FRAME, DIR_SPEED_ID, 1'b1, LEN_SPEED, 64'h00007FF8_00000000, 32'd6000, 1'b0, 3'b000},
    '{FUNC_FRAME, DIR_SPEED_ID, 1'b1, LEN_SPEED, 64'h0, 32'd6100, 1'b0, 3'b000},
    '{FUNC_FRAME, DIR_STATUS_ID, 1'b1, LEN_STATUS, 64'h00000030_00000000, 32'd6200, 1'b0,
      3'b000},
    '{FUNC_FRAME, DIR_STATUS_ID, 1'b1, LEN_STATUS, 64'h0, 32'd6300, 1'b0, 3'b000},
    '{FUNC_FRAME, DIR_DIAG_ID, 1'b0, LEN_DIAG, 64'h00000321_00000000, 32'd6400, 1'b0, 3'b000},
    '{FUNC_FRAME, DIR_DIAG_ID, 1'b0, LEN_DIAG, 64'h00000401_00000000, 32'd6500, 1'b0, 3'b000},
    '{FUNC_FRAME, DIR_DIAG_ID, 1'b0, LEN_DIAG, 64'h00020301_00000000, 32'd6600, 1'b0, 3'b000},
    '{FUNC_FRAME, DIR_DIAG_ID, 1'b0, LEN_DIAG, 64'h00000300_00000000, 32'd6700, 1'b0, 3'b000},
    // safe again just before the ms counter wraps, granted after it
    '{FUNC_FRAME, DIR_DIAG_ID, 1'b0, LEN_DIAG, 64'h00000301_00000000, 32'hFFFFF000, 1'b0,
      3'b000},
    '{FUNC_POLL,  29'h0, 1'b0, 4'd0, 64'h0, 32'h00000388, 1'b0, 3'b000},
    '{FUNC_FRAME, DIR_DIAG_ID, 1'b0, 4'd0, 64'h0, 32'h00000400, 1'b1, 3'b000},
    '{FUNC_POLL,  29'h1FFFFFFF, 1'b1, 4'hF, 64'hFFFFFFFF_FFFFFFFF, 32'd0, 1'b1, 3'b000}
  };

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        func_i         = 1'b0;
  logic [28:0] can_id_i       = '0;
  logic        is_extended_i  = 1'b0;
  logic [3:0]  frame_length_i = '0;
  logic [63:0] frame_data_i   = '0;
  logic [31:0] now_ms_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic        update_allowed_o;
  logic        stable_safe_o;
  logic        frame_accepted_o;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [4:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  // mirror of the monitor state
  cfg_t        mirror_cfg;
  sig_t        mirror_sig;
  logic [3:0]  mirror_seen;
  logic [31:0] mirror_stamp [NUM_SRC];
  logic        mirror_safe;
  logic [31:0] mirror_safe_start;

  verdict_t    expected_verdicts [$];
  verdict_t    head_verdict;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  logic [31:0] stim_ms        = '0;
  int unsigned stim_step_ms   = 0;

  can_safety_interlock_monitor_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .can_id_i         (can_id_i),
    .is_extended_i    (is_extended_i),
    .frame_length_i   (frame_length_i),
    .frame_data_i     (frame_data_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .update_allowed_o (update_allowed_o),
    .stable_safe_o    (stable_safe_o),
    .frame_accepted_o (frame_accepted_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // run time guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic got, logic want);
    $display("%0t ns mismatch on %s: got %b want %b", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic is_fresh(logic [1:0] s, logic [31:0] now);
    logic [31:0] age;
    age = now - mirror_stamp[s];
    return mirror_seen[s] && (age <= mirror_cfg.fresh_limit);
  endfunction

  // safety check and stable-time bookkeeping
  function automatic void settle_stable(logic [31:0] now);
    logic safe_now;
    safe_now = is_fresh(SRC_SPEED, now) && is_fresh(SRC_STATUS, now) &&
               is_fresh(SRC_COMMAND, now) && is_fresh(SRC_DIAG, now) &&
               mirror_sig.motor_speed == '0 && mirror_sig.drive_action == '0 &&
               mirror_sig.pedal_position == '0 && mirror_sig.output_target == '0 &&
               mirror_sig.throttle_level == '0 && mirror_sig.regen_level == '0 &&
               mirror_sig.gear_state == GEAR_PARK && mirror_sig.brake_on &&
               !mirror_sig.comm_fault && (mirror_sig.timeout_bits & TIMEOUT_MASK) == '0;
    if (!safe_now) begin
      mirror_safe       = 1'b0;
      mirror_safe_start = '0;
    end else if (!mirror_safe) begin
      mirror_safe       = 1'b1;
      mirror_safe_start = now;
    end
  endfunction

  // advance the mirror by one item and give the verdict it should produce
  function automatic verdict_t predict_verdict(frame_item_t it);
    verdict_t    v;
    logic        hit;
    logic [1:0]  src;
    logic [3:0]  want_len;
    logic [31:0] elapsed;
    v        = '0;
    hit      = 1'b1;
    src      = SRC_SPEED;
    want_len = LEN_SPEED;
    if (it.func == FUNC_POLL) begin
      settle_stable(it.now);
      elapsed   = it.now - mirror_safe_start;
      v.allowed = mirror_safe && (elapsed >= mirror_cfg.stable_time);
    end else begin
      // first matching source wins
      if (it.ext && it.can_id == mirror_cfg.speed_id) begin
        src      = SRC_SPEED;
        want_len = LEN_SPEED;
      end else if (it.ext && it.can_id == mirror_cfg.status_id) begin
        src      = SRC_STATUS;
        want_len = LEN_STATUS;
      end else if (!it.ext && it.can_id == {18'd0, mirror_cfg.command_id}) begin
        src      = SRC_COMMAND;
        want_len = LEN_COMMAND;
      end else if (!it.ext && it.can_id == {18'd0, mirror_cfg.diag_id}) begin
        src      = SRC_DIAG;
        want_len = LEN_DIAG;
      end else begin
        hit = 1'b0;
      end
      if (hit) begin
        mirror_seen[src] = (it.len == want_len);
        if (it.len == want_len) begin
          // unpack the signals carried by this source
          case (src)
            SRC_SPEED: begin
              mirror_sig.motor_speed = it.data[46:35];
            end
            SRC_STATUS: begin
              mirror_sig.pedal_position = it.data[11:2];
              mirror_sig.output_target  = it.data[35:26];
              mirror_sig.drive_action   = it.data[37:36];
            end
            SRC_COMMAND: begin
              mirror_sig.throttle_level = it.data[15:0];
              mirror_sig.regen_level    = it.data[31:16];
            end
            default: begin
              mirror_sig.brake_on     = it.data[32];
              mirror_sig.comm_fault   = it.data[37];
              mirror_sig.gear_state   = it.data[47:40];
              mirror_sig.timeout_bits = it.data[55:48];
            end
          endcase
          mirror_stamp[src] = it.now;
          v.accepted        = 1'b1;
        end
        settle_stable(it.now);
      end
    end
    v.safe = mirror_safe;
    return v;
  endfunction

  // ms clock for generated items: small steps, rare jumps and one-ms steps back
  function automatic logic [31:0] advance_ms();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2) begin
      stim_ms = $urandom();
    end else if (roll < 4) begin
      stim_ms = stim_ms - 32'd1;
    end else begin
      stim_ms = stim_ms + $urandom_range(stim_step_ms);
    end
    return stim_ms;
  endfunction

  // poll or stray frame with random content
  function automatic frame_item_t random_item(func_e f);
    frame_item_t it;
    it.func   = f;
    it.can_id = 29'($urandom());
    if ($urandom_range(1) == 0) begin
      it.can_id[28:11] = '0;
    end
    it.ext  = 1'($urandom());
    it.len  = 4'($urandom());
    it.data = {$urandom(), $urandom()};
    it.now  = advance_ms();
    return it;
  endfunction

  // frame from a configured source, at rest or with random signals
  function automatic frame_item_t source_frame(logic [1:0] src, logic at_rest, logic len_ok);
    frame_item_t it;
    logic [3:0]  good_len;
    it.func = FUNC_FRAME;
    it.data = {$urandom(), $urandom()};
    case (src)
      SRC_SPEED: begin
        it.can_id = mirror_cfg.speed_id;
        it.ext    = 1'b1;
        good_len  = LEN_SPEED;
        if (at_rest) it.data[46:35] = '0;
      end
      SRC_STATUS: begin
        it.can_id = mirror_cfg.status_id;
        it.ext    = 1'b1;
        good_len  = LEN_STATUS;
        if (at_rest) begin
          it.data[37:26] = '0;
          it.data[11:2]  = '0;
        end
      end
      SRC_COMMAND: begin
        it.can_id = {18'd0, mirror_cfg.command_id};
        it.ext    = 1'b0;
        good_len  = LEN_COMMAND;
        if (at_rest) it.data[31:0] = '0;
      end
      default: begin
        it.can_id = {18'd0, mirror_cfg.diag_id};
        it.ext    = 1'b0;
        good_len  = LEN_DIAG;
        if (at_rest) begin
          it.data[32]    = 1'b1;
          it.data[37]    = 1'b0;
          it.data[47:40] = GEAR_PARK;
          it.data[55:48] = it.data[55:48] & ~TIMEOUT_MASK;
        end
      end
    endcase
    it.len = good_len;
    while (!len_ok && it.len == good_len) begin
      it.len = 4'($urandom());
    end
    it.now = advance_ms();
    return it;
  endfunction

  // present one item, hold it until taken, then record what it should give
  task automatic send_item(frame_item_t it, logic typed, verdict_t typed_want);
    verdict_t v;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    func_i         <= it.func;
    can_id_i       <= it.can_id;
    is_extended_i  <= it.ext;
    frame_length_i <= it.len;
    frame_data_i   <= it.data;
    now_ms_i       <= it.now;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    v = predict_verdict(it);
    expected_verdicts.push_back(typed ? typed_want : v);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SPEED_ID:    mirror_cfg.speed_id    = val[28:0];
      REG_STATUS_ID:   mirror_cfg.status_id   = val[28:0];
      REG_COMMAND_ID:  mirror_cfg.command_id  = val[10:0];
      REG_DIAG_ID:     mirror_cfg.diag_id     = val[10:0];
      REG_FRESH_LIMIT: mirror_cfg.fresh_limit = val;
      REG_STABLE_TIME: mirror_cfg.stable_time = val;
      default: ;
    endcase
  endtask

  // drain the pipeline, then load a full register set
  task automatic configure(logic [31:0] speed_id, logic [31:0] status_id,
                           logic [31:0] command_id, logic [31:0] diag_id,
                           logic [31:0] fresh_ms, logic [31:0] stable_ms);
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_SPEED_ID, speed_id);
    write_reg(REG_STATUS_ID, status_id);
    write_reg(REG_COMMAND_ID, command_id);
    write_reg(REG_DIAG_ID, diag_id);
    write_reg(REG_FRESH_LIMIT, fresh_ms);
    write_reg(REG_STABLE_TIME, stable_ms);
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    // time steps kept well inside the freshness and stable windows
    stim_step_ms = mirror_cfg.fresh_limit >> 3;
    if ((mirror_cfg.stable_time >> 3) < stim_step_ms) begin
      stim_step_ms = mirror_cfg.stable_time >> 3;
    end
  endtask

  // rounds of all four sources in random order followed by polls,
  // with stray frames, dropped frames, bad lengths and moving signals mixed in
  task automatic run_phase(int unsigned quota);
    logic [1:0]  order [$];
    int unsigned counted;
    int unsigned pick;
    logic [1:0]  src;
    counted = 0;
    while (counted < quota) begin
      order = '{SRC_SPEED, SRC_STATUS, SRC_COMMAND, SRC_DIAG};
      while (order.size() != 0) begin
        pick = $urandom_range(order.size() - 1);
        src  = order[pick];
        order.delete(pick);
        if ($urandom_range(99) < 10) begin
          send_item(random_item(FUNC_FRAME), 1'b0, '0);
        end
        if ($urandom_range(99) >= 5) begin
          send_item(source_frame(src, $urandom_range(99) >= 4, $urandom_range(99) >= 3),
                    1'b0, '0);
          counted++;
        end
      end
      repeat ($urandom_range(2, 1)) begin
        send_item(random_item(FUNC_POLL), 1'b0, '0);
        counted++;
      end
    end
  endtask

  // result side: random stall and in-order compare
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result with nothing pending", 1'b1, 1'b0);
      end else begin
        head_verdict = expected_verdicts.pop_front();
        if (update_allowed_o !== head_verdict.allowed) begin
          report_mismatch("update_allowed", update_allowed_o, head_verdict.allowed);
        end
        if (stable_safe_o !== head_verdict.safe) begin
          report_mismatch("stable_safe", stable_safe_o, head_verdict.safe);
        end
        if (frame_accepted_o !== head_verdict.accepted) begin
          report_mismatch("frame_accepted", frame_accepted_o, head_verdict.accepted);
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  initial begin
    frame_item_t row_item;
    mirror_cfg        = '0;
    mirror_cfg.fresh_limit = FRESH_LIMIT_RST;
    mirror_cfg.stable_time = STABLE_TIME_RST;
    mirror_sig        = '0;
    mirror_seen       = '0;
    mirror_safe       = 1'b0;
    mirror_safe_start = '0;
    for (int s = 0; s < NUM_SRC; s++) begin
      mirror_stamp[s] = '0;
    end

    // reset
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, sender idles lightly and receiver stalls heavily
    tx_idle_pct  = 24;
    rx_stall_pct = 63;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (r == RESET_ROWS) begin
        configure(DIR_SPEED_ID, DIR_STATUS_ID, DIR_CMD_ID, DIR_DIAG_ID, 32'hFFFFFFFF,
                  STABLE_TIME_RST);
      end
      row_item.func   = DIRECTED[r].func;
      row_item.can_id = DIRECTED[r].can_id;
      row_item.ext    = DIRECTED[r].ext;
      row_item.len    = DIRECTED[r].len;
      row_item.data   = DIRECTED[r].data;
      row_item.now    = DIRECTED[r].now;
      send_item(row_item, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // random phases over several register settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: configure(32'h00000123, 32'h00000456, 32'h00000321, 32'h00000654,
                     FRESH_LIMIT_RST, STABLE_TIME_RST);
        1: configure(32'h1FFFFFFF, 32'h00000000, 32'h00000000, 32'h000007FF,
                     32'd0, 32'd0);
        2: configure(32'($urandom_range(32'h1FFFFFFF)), 32'h15555555, 32'h000002AA,
                     32'h00000555, 32'hFFFFFFFF, 32'hFFFFFFFF);
        3: configure(32'h0ABCDEF0, 32'h0ABCDEF0, 32'h00000100, 32'h00000100,
                     32'd400, 32'd800);
        4: configure(32'h00000000, 32'h00000001, 32'h00000000, 32'h00000001,
                     $urandom_range(3000), $urandom_range(3000));
        default: configure($urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom_range(5000, 200), $urandom_range(8000));
      endcase
      if (ph == 2) begin
        tx_idle_pct  = 63;
        rx_stall_pct = 24;
      end else if (ph == 4) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      run_phase(PHASE_ITEMS);
    end

    // wait for the last results to drain
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/csim_pkg.sv
hdl/csim_cfg.sv
hdl/csim_decode.sv
hdl/csim_safety.sv
hdl/can_safety_interlock_monitor_unit.sv
hdl/csim_checker.sv
tb/tb_can_safety_interlock_monitor_unit.sv
